// ===== src/nkd_pkg.sv =====
// Shared types, constants and helper functions for the nibble key descrambler.
`timescale 1ns / 1ps

package nkd_pkg;

    localparam int KEY_W  = 32;
    localparam int NIB_W  = 4;
    localparam int BYTE_W = 8;
    localparam int RING_W = 3;
    localparam int ADDR_W = 3;

    // Ring positions: position p selects the key nibble at shift 16 - 4*p.
    localparam logic [RING_W-1:0] RING_FIRST = 3'd0;
    localparam logic [RING_W-1:0] RING_LAST  = 3'd4;

    // Word index of the key register in the configuration map.
    localparam logic [ADDR_W-3:0] REG_UNLOCK_KEY = 1'b0;

    // Key and its precomputed sum term, handed from the register block to the datapath.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [NIB_W-1:0] key_sum;
    } key_cfg_t;

    function automatic logic [NIB_W-1:0] nib_table(input logic [NIB_W-1:0] idx);
        logic [NIB_W-1:0] val;
        case (idx)
            4'h0: val = 4'hb;
            4'h1: val = 4'hc;
            4'h2: val = 4'ha;
            4'h3: val = 4'h0;
            4'h4: val = 4'h8;
            4'h5: val = 4'hf;
            4'h6: val = 4'h2;
            4'h7: val = 4'h1;
            4'h8: val = 4'h6;
            4'h9: val = 4'h4;
            4'ha: val = 4'h9;
            4'hb: val = 4'h3;
            4'hc: val = 4'hd;
            4'hd: val = 4'h5;
            4'he: val = 4'h7;
            default: val = 4'he;
        endcase
        return val;
    endfunction

    // The low nibble of the sum of the shifted key words only depends on
    // the low nibble of each byte.
    function automatic logic [NIB_W-1:0] key_sum_of(input logic [KEY_W-1:0] key);
        logic [NIB_W-1:0] s;
        s = key[27:24] + key[19:16] + key[11:8] + key[3:0];
        return nib_table(s);
    endfunction

    function automatic logic [NIB_W-1:0] ring_nibble(input logic [KEY_W-1:0] key,
                                                     input logic [RING_W-1:0] pos);
        logic [NIB_W-1:0] kn;
        case (pos)
            3'd1: kn = key[15:12];
            3'd2: kn = key[11:8];
            3'd3: kn = key[7:4];
            3'd4: kn = key[3:0];
            default: kn = key[19:16];
        endcase
        return kn;
    endfunction

    function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] pos);
        logic [RING_W-1:0] nxt;
        if (pos >= RING_LAST) begin
            nxt = RING_FIRST;
        end else begin
            nxt = pos + 3'd1;
        end
        return nxt;
    endfunction

endpackage

// ===== src/nkd_cfg_regs.sv =====
// APB register block holding the unlock key and its derived sum term.
`timescale 1ns / 1ps

module nkd_cfg_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nkd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output nkd_pkg::key_cfg_t           key_cfg
);

    logic [nkd_pkg::KEY_W-1:0] key_reg;
    logic [nkd_pkg::NIB_W-1:0] key_sum_reg;
    logic                      hit_key;
    logic                      wr_en;

    assign pready  = 1'b1;
    assign hit_key = (paddr[nkd_pkg::ADDR_W-1:2] == nkd_pkg::REG_UNLOCK_KEY);
    assign wr_en   = psel && penable && pwrite && pready;

    // The sum term is folded in at write time so the byte path sees a constant.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            key_sum_reg <= nkd_pkg::key_sum_of('0);
        end else if (wr_en && hit_key) begin
            key_reg     <= pwdata;
            key_sum_reg <= nkd_pkg::key_sum_of(pwdata);
        end
    end

    always_comb begin
        prdata = '0;
        if (hit_key) begin
            prdata = key_reg;
        end
    end

    assign key_cfg.key     = key_reg;
    assign key_cfg.key_sum = key_sum_reg;

endmodule

// ===== src/nkd_nibble_unit.sv =====
// Descrambles one nibble against the key at a given ring position.
`timescale 1ns / 1ps

module nkd_nibble_unit (
    input  nkd_pkg::key_cfg_t           key_cfg,
    input  logic [nkd_pkg::RING_W-1:0]  ring_pos,
    input  logic [nkd_pkg::NIB_W-1:0]   cipher_nib,
    output logic [nkd_pkg::NIB_W-1:0]   plain_nib
);

    logic [nkd_pkg::NIB_W-1:0] kn;

    assign kn = nkd_pkg::ring_nibble(key_cfg.key, ring_pos);

    // All terms wrap modulo 16 in the 4-bit subtraction.
    assign plain_nib = cipher_nib - key_cfg.key_sum - kn - nkd_pkg::nib_table(kn);

endmodule

// ===== src/nibble_key_descrambler.sv =====
// Top level of the nibble key descrambler: stream ports, ring counter and pipeline.
`timescale 1ns / 1ps

// Takes one scrambled byte per clock unless back-pressure on m_tready fills both registers,
// and returns one descrambled byte for each through an input register and then a result
// register; a full result register blocks intake only while the input register is also full,
// since the input register takes the next word while the result waits. Each byte consumes
// two ring steps, upper nibble first, and a byte with tlast set returns the ring to its first
// position. The unlock key lives at byte address 0 of the APB port and should only be written
// while no words are in flight.
module nibble_key_descrambler (
    input  logic                        aclk,
    input  logic                        aresetn,
    // APB configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nkd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // Scrambled input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] cipher_byte
    input  logic                        s_tlast,   // last_in_block
    // Descrambled output stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata    // [7:0] plain_byte
);

    nkd_pkg::key_cfg_t key_cfg;

    logic [nkd_pkg::RING_W-1:0] ring_reg, ring_next;
    logic [nkd_pkg::RING_W-1:0] ring_lo;

    logic                        in_valid_reg, in_valid_next;
    logic [nkd_pkg::BYTE_W-1:0]  in_byte_reg;
    logic [nkd_pkg::RING_W-1:0]  in_pos_reg;

    logic                        out_valid_reg, out_valid_next;
    logic [nkd_pkg::BYTE_W-1:0]  out_byte_reg;

    logic                        out_free;
    logic                        s_accept;
    logic [nkd_pkg::NIB_W-1:0]   plain_hi, plain_lo;

    nkd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key_cfg (key_cfg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // The ring advances at intake; the position for the upper nibble travels with the word.
    always_comb begin
        ring_next = ring_reg;
        if (s_accept) begin
            if (s_tlast) begin
                ring_next = nkd_pkg::RING_FIRST;
            end else begin
                ring_next = nkd_pkg::ring_next(nkd_pkg::ring_next(ring_reg));
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_reg      <= nkd_pkg::RING_FIRST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ring_reg      <= ring_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_pos_reg  <= ring_reg;
        end
        if (out_free && in_valid_reg) begin
            out_byte_reg <= {plain_hi, plain_lo};
        end
    end

    assign ring_lo = nkd_pkg::ring_next(in_pos_reg);

    nkd_nibble_unit u_hi (
        .key_cfg    (key_cfg),
        .ring_pos   (in_pos_reg),
        .cipher_nib (in_byte_reg[7:4]),
        .plain_nib  (plain_hi)
    );

    nkd_nibble_unit u_lo (
        .key_cfg    (key_cfg),
        .ring_pos   (ring_lo),
        .cipher_nib (in_byte_reg[3:0]),
        .plain_nib  (plain_lo)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the nibble key descrambler: directed and random byte streams.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [nkd_pkg::ADDR_W-1:0] KEY_ADDR = {nkd_pkg::REG_UNLOCK_KEY, 2'b00};

    // Nibble substitution table, used both for the key sum and for the ring nibble.
    localparam logic [3:0] NIB_SUBST [16] = '{
        4'hb, 4'hc, 4'ha, 4'h0,
        4'h8, 4'hf, 4'h2, 4'h1,
        4'h6, 4'h4, 4'h9, 4'h3,
        4'hd, 4'h5, 4'h7, 4'he
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [nkd_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [7:0] cipher_byte
    logic        s_tlast  = 1'b0;   // last_in_block
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [7:0] plain_byte

    logic [31:0] key_model;
    logic [2:0]  ring_model;
    logic [7:0]  plain_expected [$];
    logic [7:0]  plain_want;
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    nibble_key_descrambler u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nibble_key_descrambler verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic logic [3:0] unmask_nibble(input logic [3:0] nib, input logic [2:0] pos);
        logic [31:0] sum;
        logic [31:0] shifted;
        logic [3:0]  kn;
        sum     = (key_model >> 24) + (key_model >> 16) + (key_model >> 8) + key_model;
        shifted = key_model >> (16 - 4 * int'(pos));
        kn      = shifted[3:0];
        return nib - NIB_SUBST[sum[3:0]] - kn - NIB_SUBST[kn];
    endfunction

    function automatic logic [2:0] ring_step(input logic [2:0] pos);
        return (pos >= nkd_pkg::RING_LAST) ? nkd_pkg::RING_FIRST : pos + 3'd1;
    endfunction

    // Each word consumes two ring steps; a word marked last sends the ring home.
    function automatic logic [7:0] predict_plain(input logic [7:0] cipher, input logic last);
        logic [3:0] upper;
        logic [3:0] lower;
        upper      = unmask_nibble(cipher[7:4], ring_model);
        ring_model = ring_step(ring_model);
        lower      = unmask_nibble(cipher[3:0], ring_model);
        ring_model = last ? nkd_pkg::RING_FIRST : ring_step(ring_model);
        return {upper, lower};
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (plain_expected.size() == 0) begin
                $error("plain_byte: expected none, actual %02h", m_tdata);
                mismatches++;
            end else begin
                plain_want = plain_expected.pop_front();
                if (m_tdata !== plain_want) begin
                    $error("plain_byte: expected %02h, actual %02h", plain_want, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(input logic [7:0] cipher, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cipher;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        plain_expected.push_back(predict_plain(cipher, last));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (plain_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // The ring position is deliberately left alone: a key change mid-block keeps it.
    task automatic write_key(input logic [31:0] key);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= KEY_ADDR;
        pwdata  <= key;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        key_model = key;
        @(posedge aclk);
    endtask

    task automatic read_key_back();
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= KEY_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== key_model) begin
            $error("unlock_key: expected %08h, actual %08h", key_model, got);
            mismatches++;
        end
        @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key();
        logic [31:0] key;
        case ($urandom_range(5))
            0: key = 32'h0000_0000;
            1: key = 32'hffff_ffff;
            default: key = $urandom;
        endcase
        return key;
    endfunction

    task automatic test_default_key();
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'ha5, 1'b1);
    endtask

    task automatic test_register_access();
        write_key(32'hffff_ffff);
        read_key_back();
        write_key(32'h0000_0000);
        read_key_back();
        write_key($urandom);
        read_key_back();
    endtask

    task automatic test_extreme_key();
        write_key(32'hffff_ffff);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        send_word(8'h0f, 1'b0);
        send_word(8'hf0, 1'b1);
    endtask

    // Distinct key nibbles make every ring shift visible, including the wrap.
    task automatic test_ring_positions();
        write_key(32'h89ab_cdef);
        for (int i = 0; i < 5; i++) begin
            send_word(8'h3c + 8'(i * 37), 1'b0);
        end
        send_word(8'h5a, 1'b1);
        send_word(8'h96, 1'b1);
        send_word(8'h11, 1'b0);
        send_word(8'hee, 1'b1);
    endtask

    task automatic test_key_mid_block();
        write_key(32'h1357_9bdf);
        send_word(8'h42, 1'b0);
        send_word(8'hbd, 1'b0);
        write_key(32'hfdb9_7531);
        send_word(8'h7e, 1'b0);
        send_word(8'h81, 1'b1);
    endtask

    // Blocks of random length; most end with the last marker, a few run on into the
    // next block and a few carry a stray marker in the middle.
    task automatic test_random_blocks(input int tx_pct, input int rx_pct, input int n_words);
        int sent;
        int len;
        logic last;
        wait_drained();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_key(pick_key());
        sent = 0;
        while (sent < n_words) begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++) begin
                if (i == len - 1) begin
                    last = ($urandom_range(9) != 0);
                end else begin
                    last = ($urandom_range(19) == 0);
                end
                send_word(8'($urandom), last);
                sent++;
            end
            if ($urandom_range(5) == 0) begin
                write_key(pick_key());
            end else if ($urandom_range(15) == 0) begin
                wait_drained();
            end
        end
    endtask

    initial begin
        key_model  = '0;
        ring_model = nkd_pkg::RING_FIRST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_key();
        test_register_access();
        test_extreme_key();
        test_ring_positions();
        test_key_mid_block();
        test_random_blocks(23, 79, 165);
        test_random_blocks(79, 23, 165);
        test_random_blocks(0, 0, 170);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("nibble_key_descrambler verification clean");
        end else begin
            $display("nibble_key_descrambler verification failed");
        end
        $finish;
    end

endmodule
